// ===== design/mcftt_pkg.sv =====
package mcftt_pkg;

  localparam int CHANNELS_DEF = 16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_NEXT     = 2'd0,
    MODE_EVERY    = 2'd1,
    MODE_ONESHOT  = 2'd2,
    MODE_PERIODIC = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_ABSENT   = 3'd3,
    ST_FIRED    = 3'd4,
    ST_TICKDONE = 3'd5,
    ST_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_FIND_RD,
    S_FIND_CHK,
    S_MV_RD,
    S_MV_WR,
    S_TK_RD,
    S_TK_CALC,
    S_TK_PER,
    S_TK_EMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0]        ident;
    mode_t              mode;
    logic signed [33:0] remaining;
    logic [31:0]        period;
    logic               unscaled;
    logic [31:0]        events;
  } slot_t;

endpackage

// ===== design/mcftt_slot_ram.sv =====
module mcftt_slot_ram import mcftt_pkg::*; #(
  parameter int DEPTH = CHANNELS_DEF,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  slot_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output slot_t         rdata
);

  slot_t mem [DEPTH];
  slot_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mcftt_alu.sv =====
module mcftt_alu import mcftt_pkg::*; (
  input  logic signed [33:0] a,
  input  logic signed [33:0] b,
  input  logic               sub,
  output logic signed [33:0] sum,
  output logic               le_zero
);

  always_comb begin
    sum     = sub ? (a - b) : (a + b);
    le_zero = sum[33] || (sum == 34'sd0);
  end

endmodule

// ===== design/multi_channel_frame_timer_table.sv =====
// channel  | handshake                | fields
// in       | in_valid / in_ready      | in_op, in_mode, in_period, in_use_unscaled,
//          |                          | in_target_id, in_delta_scaled, in_delta_unscaled
// out      | out_valid / out_ready    | out_status, out_chan_id, out_event_count,
//          |                          | out_finished, out_last
// add writes one slot, clear resets the fill count, remove scans and moves slots
// down, a tick visits every live channel (one step more when a periodic one fires);
// one shared adder and a slot memory with registered read serve all of these
// reset empties the table at once through the fill count, no clearing pass
// a word waiting in the output register stalls the sequencer only at its next emit
module multi_channel_frame_timer_table import mcftt_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_period,
  input  logic               in_use_unscaled,
  input  logic [31:0]        in_target_id,
  input  logic signed [31:0] in_delta_scaled,
  input  logic signed [31:0] in_delta_unscaled,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic [31:0]        out_chan_id,
  output logic [31:0]        out_event_count,
  output logic               out_finished,
  output logic               out_last
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNELS + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   rd_r, rd_nxt;
  logic [CNT_W-1:0]   wr_r, wr_nxt;
  logic [31:0]        id_ctr_r, id_ctr_nxt;
  mode_t              mode_r, mode_nxt;
  logic [31:0]        period_r, period_nxt;
  logic               unsc_r, unsc_nxt;
  logic [31:0]        target_r, target_nxt;
  logic [30:0]        ds_r, ds_nxt;
  logic [30:0]        du_r, du_nxt;
  slot_t              rec_r, rec_nxt;
  logic               fire_r, fire_nxt;
  logic               done_r, done_nxt;
  status_t            pend_st_r, pend_st_nxt;
  logic [31:0]        pend_id_r, pend_id_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_st_r, out_st_nxt;
  logic [31:0]        out_id_r, out_id_nxt;
  logic [31:0]        out_ev_r, out_ev_nxt;
  logic               out_fin_r, out_fin_nxt;
  logic               out_last_r, out_last_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  slot_t              ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  slot_t              ram_rdata;

  logic signed [33:0] alu_a, alu_b, alu_sum;
  logic               alu_sub, alu_le0;

  logic               out_free;
  logic [CNT_W-1:0]   rd_inc;
  logic [CNT_W-1:0]   wr_new;
  logic               p_le0;
  logic [31:0]        p_min1;
  slot_t              new_rec;
  slot_t              wb_rec;
  logic [30:0]        cur_delta;

  mcftt_slot_ram #(
    .DEPTH (CHANNELS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mcftt_alu u_alu (
    .a       (alu_a),
    .b       (alu_b),
    .sub     (alu_sub),
    .sum     (alu_sum),
    .le_zero (alu_le0)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      id_ctr_r    <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      id_ctr_r    <= id_ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r       <= rd_nxt;
    wr_r       <= wr_nxt;
    mode_r     <= mode_nxt;
    period_r   <= period_nxt;
    unsc_r     <= unsc_nxt;
    target_r   <= target_nxt;
    ds_r       <= ds_nxt;
    du_r       <= du_nxt;
    rec_r      <= rec_nxt;
    fire_r     <= fire_nxt;
    done_r     <= done_nxt;
    pend_st_r  <= pend_st_nxt;
    pend_id_r  <= pend_id_nxt;
    out_st_r   <= out_st_nxt;
    out_id_r   <= out_id_nxt;
    out_ev_r   <= out_ev_nxt;
    out_fin_r  <= out_fin_nxt;
    out_last_r <= out_last_nxt;
  end

  // new slot record for an add
  always_comb begin
    p_le0            = period_r[31] || (period_r == 32'd0);
    p_min1           = p_le0 ? 32'd1 : period_r;
    new_rec          = '0;
    new_rec.ident    = id_ctr_r;
    new_rec.mode     = mode_r;
    new_rec.unscaled = unsc_r;
    new_rec.events   = 32'd0;
    case (mode_r)
      MODE_ONESHOT: begin
        new_rec.remaining = period_r[31] ? 34'sd0 : $signed({2'b00, period_r});
        new_rec.period    = p_min1;
      end
      MODE_PERIODIC: begin
        new_rec.remaining = $signed({2'b00, p_min1});
        new_rec.period    = p_min1;
      end
      default: begin
        new_rec.remaining = 34'sd0;
        new_rec.period    = 32'd1;
      end
    endcase
  end

  always_comb begin
    out_free = !out_valid_r || out_ready;
    rd_inc   = rd_r + CNT_W'(1);
    wr_new   = done_r ? wr_r : (wr_r + CNT_W'(1));
    cur_delta = ram_rdata.unscaled ? du_r : ds_r;
    wb_rec        = rec_r;
    wb_rec.events = rec_r.events + {31'd0, fire_r};

    state_nxt   = state_r;
    count_nxt   = count_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    id_ctr_nxt  = id_ctr_r;
    mode_nxt    = mode_r;
    period_nxt  = period_r;
    unsc_nxt    = unsc_r;
    target_nxt  = target_r;
    ds_nxt      = ds_r;
    du_nxt      = du_r;
    rec_nxt     = rec_r;
    fire_nxt    = fire_r;
    done_nxt    = done_r;
    pend_st_nxt = pend_st_r;
    pend_id_nxt = pend_id_r;

    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_st_nxt    = out_st_r;
    out_id_nxt    = out_id_r;
    out_ev_nxt    = out_ev_r;
    out_fin_nxt   = out_fin_r;
    out_last_nxt  = out_last_r;

    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wr_r[IDX_W-1:0];
    ram_wdata = wb_rec;
    ram_re    = 1'b0;
    ram_raddr = rd_r[IDX_W-1:0];
    alu_a     = rec_r.remaining;
    alu_b     = 34'sd0;
    alu_sub   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_valid) begin
          mode_nxt   = mode_t'(in_mode);
          period_nxt = in_period;
          unsc_nxt   = in_use_unscaled;
          target_nxt = in_target_id;
          ds_nxt     = in_delta_scaled[31] ? 31'd0 : in_delta_scaled[30:0];
          du_nxt     = in_delta_unscaled[31] ? 31'd0 : in_delta_unscaled[30:0];
          rd_nxt     = '0;
          wr_nxt     = '0;
          unique case (op_t'(in_op))
            OP_ADD: begin
              state_nxt = S_ADD;
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                pend_st_nxt = ST_ABSENT;
                pend_id_nxt = in_target_id;
                state_nxt   = S_DONE;
              end else begin
                state_nxt = S_FIND_RD;
              end
            end
            OP_TICK: begin
              if (count_r == '0) begin
                pend_st_nxt = ST_TICKDONE;
                pend_id_nxt = 32'd0;
                state_nxt   = S_DONE;
              end else begin
                state_nxt = S_TK_RD;
              end
            end
            OP_CLEAR: begin
              count_nxt   = '0;
              pend_st_nxt = ST_CLEARED;
              pend_id_nxt = 32'd0;
              state_nxt   = S_DONE;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ADD: begin
        if (count_r == CNT_W'(CHANNELS)) begin
          pend_st_nxt = ST_FULL;
          pend_id_nxt = 32'd0;
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = count_r[IDX_W-1:0];
          ram_wdata   = new_rec;
          count_nxt   = count_r + CNT_W'(1);
          id_ctr_nxt  = (id_ctr_r == 32'hFFFF_FFFF) ? 32'd1 : (id_ctr_r + 32'd1);
          pend_st_nxt = ST_ADDED;
          pend_id_nxt = id_ctr_r;
        end
        state_nxt = S_DONE;
      end

      S_FIND_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_FIND_CHK;
      end

      S_FIND_CHK: begin
        rd_nxt = rd_inc;
        if (ram_rdata.ident == target_r) begin
          wr_nxt = rd_r;
          if (rd_inc == count_r) begin
            count_nxt   = count_r - CNT_W'(1);
            pend_st_nxt = ST_REMOVED;
            pend_id_nxt = target_r;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_MV_RD;
          end
        end else if (rd_inc == count_r) begin
          pend_st_nxt = ST_ABSENT;
          pend_id_nxt = target_r;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_FIND_RD;
        end
      end

      S_MV_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_MV_WR;
      end

      S_MV_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        wr_nxt    = wr_r + CNT_W'(1);
        rd_nxt    = rd_inc;
        if (rd_inc == count_r) begin
          count_nxt   = count_r - CNT_W'(1);
          pend_st_nxt = ST_REMOVED;
          pend_id_nxt = target_r;
          state_nxt   = S_DONE;
        end else begin
          state_nxt = S_MV_RD;
        end
      end

      S_TK_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_TK_CALC;
      end

      S_TK_CALC: begin
        alu_a     = ram_rdata.remaining;
        alu_b     = $signed({3'b000, cur_delta});
        alu_sub   = 1'b1;
        rec_nxt   = ram_rdata;
        state_nxt = S_TK_EMIT;
        unique case (ram_rdata.mode)
          MODE_NEXT: begin
            fire_nxt = 1'b1;
            done_nxt = 1'b1;
          end
          MODE_EVERY: begin
            fire_nxt = 1'b1;
            done_nxt = 1'b0;
          end
          MODE_ONESHOT: begin
            rec_nxt.remaining = alu_sum;
            fire_nxt          = alu_le0;
            done_nxt          = alu_le0;
          end
          MODE_PERIODIC: begin
            rec_nxt.remaining = alu_sum;
            fire_nxt          = alu_le0;
            done_nxt          = 1'b0;
            if (alu_le0) begin
              state_nxt = S_TK_PER;
            end
          end
          default: begin
            fire_nxt = 1'b0;
            done_nxt = 1'b0;
          end
        endcase
      end

      // carry the phase over once, floored at zero
      S_TK_PER: begin
        alu_a             = rec_r.remaining;
        alu_b             = $signed({2'b00, rec_r.period});
        alu_sub           = 1'b0;
        rec_nxt.remaining = alu_sum[33] ? 34'sd0 : alu_sum;
        state_nxt         = S_TK_EMIT;
      end

      S_TK_EMIT: begin
        if (!fire_r || out_free) begin
          if (fire_r) begin
            out_valid_nxt = 1'b1;
            out_st_nxt    = ST_FIRED;
            out_id_nxt    = rec_r.ident;
            out_ev_nxt    = rec_r.events;
            out_fin_nxt   = done_r;
            out_last_nxt  = 1'b0;
          end
          ram_we = !done_r;
          wr_nxt = wr_new;
          rd_nxt = rd_inc;
          if (rd_inc == count_r) begin
            count_nxt   = wr_new;
            pend_st_nxt = ST_TICKDONE;
            pend_id_nxt = 32'd0;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_TK_RD;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = pend_st_r;
          out_id_nxt    = pend_id_r;
          out_ev_nxt    = 32'd0;
          out_fin_nxt   = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_st_r;
  assign out_chan_id     = out_id_r;
  assign out_event_count = out_ev_r;
  assign out_finished    = out_fin_r;
  assign out_last        = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CHANNELS))
    else $error("fill count beyond table size");

  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    id_ctr_r != 32'd0)
    else $error("id counter reached zero");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TK_EMIT) |-> (wr_r <= rd_r))
    else $error("tick write pointer passed read pointer");

  a_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted word did not start the sequencer");

  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_FIRED) |-> !out_last_r)
    else $error("fired word marked last");

endmodule
